// ----- src/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Input item: one raw byte or an end-of-text marker
  typedef struct packed {
    logic [7:0] char_byte;
    logic       input_end;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_QUOTE    = 4'd1,
    ERR_EARLY_END   = 4'd2,
    ERR_BAD_ESCAPE  = 4'd3,
    ERR_INCOMPLETE  = 4'd4,
    ERR_BAD_HEX     = 4'd5,
    ERR_MISSING_LOW = 4'd6,
    ERR_BAD_LOW     = 4'd7,
    ERR_LONE_LOW    = 4'd8
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_WAIT_BS = 3'd4,
    PH_WAIT_U  = 3'd5,
    PH_HEX2    = 3'd6
  } phase_e;

  typedef enum logic {
    OP_SINGLE = 1'b0,   // one result, fields given as is
    OP_CODEPT = 1'b1    // encode code point as 1 to 4 UTF-8 bytes
  } op_e;

  // Command from the front end to the encoder
  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [7:0]  data;
    err_e        err;
    logic [20:0] cp;
  } cmd_t;

  localparam int unsigned QDepth = 4;

  // Characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChLowerU = 8'h75;

  // Top six bits of high (D800..DBFF) and low (DC00..DFFF) surrogates
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;
  localparam logic [20:0] SuppBase   = 21'h10000;

  // Hex digit decode: bit 4 is the valid flag
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Number of UTF-8 bytes minus one
  function automatic logic [1:0] utf8_last(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= 21'h7F) begin
      r = 2'd0;
    end else if (cp <= 21'h7FF) begin
      r = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // Byte idx of the UTF-8 encoding of cp whose length is last+1
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                           input logic [1:0] idx);
    logic [7:0] r;
    logic [1:0] from_end;
    from_end = last - idx;
    r = 8'h00;
    if (last == 2'd0) begin
      r = cp[7:0];
    end else if (idx == 2'd0) begin
      case (last)
        2'd1:    r = {3'b110, cp[10:6]};
        2'd2:    r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0:    r = {2'b10, cp[5:0]};
        2'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/jsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Parses one raw byte per cycle while items are accepted and issues commands for the encoder.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  jsu_pkg::in_item_t item_i,
  output logic             push_o,
  output jsu_pkg::cmd_t    cmd_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [11:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;

  logic [7:0]  c;
  logic        in_end;
  logic [4:0]  hv;
  logic [15:0] v;
  logic        fail;
  jsu_pkg::err_e fail_code;
  logic        emit;
  jsu_pkg::cmd_t cmd;

  assign c      = item_i.char_byte;
  assign in_end = item_i.input_end;
  assign hv     = jsu_pkg::hex_val(c);
  assign v      = {acc_q, hv[3:0]};

  // Next state and command
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    hs_d      = hs_q;
    fail      = 1'b0;
    fail_code = jsu_pkg::ERR_NONE;
    emit      = 1'b0;
    cmd.op    = jsu_pkg::OP_SINGLE;
    cmd.kind  = jsu_pkg::KIND_DATA;
    cmd.data  = 8'h00;
    cmd.err   = jsu_pkg::ERR_NONE;
    cmd.cp    = 21'd0;

    case (phase_q)
      jsu_pkg::PH_BODY: begin
        if (in_end) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_EARLY_END;
        end else if (c == jsu_pkg::ChQuote) begin
          phase_d  = jsu_pkg::PH_IDLE;
          emit     = 1'b1;
          cmd.kind = jsu_pkg::KIND_DONE;
        end else if (c == jsu_pkg::ChBslash) begin
          phase_d = jsu_pkg::PH_ESC;
        end else begin
          emit     = 1'b1;
          cmd.data = c;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (in_end) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_EARLY_END;
        end else begin
          phase_d = jsu_pkg::PH_BODY;
          emit    = 1'b1;
          case (c)
            jsu_pkg::ChQuote:  cmd.data = c;
            jsu_pkg::ChBslash: cmd.data = c;
            jsu_pkg::ChSlash:  cmd.data = c;
            jsu_pkg::ChLowerB: cmd.data = 8'h08;
            jsu_pkg::ChLowerF: cmd.data = 8'h0C;
            jsu_pkg::ChLowerN: cmd.data = 8'h0A;
            jsu_pkg::ChLowerR: cmd.data = 8'h0D;
            jsu_pkg::ChLowerT: cmd.data = 8'h09;
            jsu_pkg::ChLowerU: begin
              emit    = 1'b0;
              phase_d = jsu_pkg::PH_HEX1;
              cnt_d   = 2'd0;
              acc_d   = 12'd0;
            end
            default: begin
              emit = 1'b0;
              fail = 1'b1; fail_code = jsu_pkg::ERR_BAD_ESCAPE;
            end
          endcase
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (in_end) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_INCOMPLETE;
        end else if (!hv[4]) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_BAD_HEX;
        end else if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
          acc_d = v[11:0];
        end else begin
          cnt_d = 2'd0;
          acc_d = 12'd0;
          if (phase_q == jsu_pkg::PH_HEX1) begin
            if (v[15:10] == jsu_pkg::HighSurrTag) begin
              hs_d    = v[9:0];
              phase_d = jsu_pkg::PH_WAIT_BS;
            end else if (v[15:10] == jsu_pkg::LowSurrTag) begin
              fail = 1'b1; fail_code = jsu_pkg::ERR_LONE_LOW;
            end else begin
              phase_d = jsu_pkg::PH_BODY;
              emit    = 1'b1;
              cmd.op  = jsu_pkg::OP_CODEPT;
              cmd.cp  = {5'd0, v};
            end
          end else begin
            if (v[15:10] != jsu_pkg::LowSurrTag) begin
              fail = 1'b1; fail_code = jsu_pkg::ERR_BAD_LOW;
            end else begin
              phase_d = jsu_pkg::PH_BODY;
              emit    = 1'b1;
              cmd.op  = jsu_pkg::OP_CODEPT;
              cmd.cp  = jsu_pkg::SuppBase + {1'b0, hs_q, v[9:0]};
            end
          end
        end
      end
      jsu_pkg::PH_WAIT_BS: begin
        if (in_end || c != jsu_pkg::ChBslash) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_MISSING_LOW;
        end else begin
          phase_d = jsu_pkg::PH_WAIT_U;
        end
      end
      jsu_pkg::PH_WAIT_U: begin
        if (in_end || c != jsu_pkg::ChLowerU) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_MISSING_LOW;
        end else begin
          phase_d = jsu_pkg::PH_HEX2;
          cnt_d   = 2'd0;
          acc_d   = 12'd0;
        end
      end
      default: begin
        if (in_end) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_EARLY_END;
        end else if (c != jsu_pkg::ChQuote) begin
          fail = 1'b1; fail_code = jsu_pkg::ERR_NO_QUOTE;
        end else begin
          phase_d = jsu_pkg::PH_BODY;
        end
      end
    endcase

    // Errors drop back to idle and report one result
    if (fail) begin
      phase_d  = jsu_pkg::PH_IDLE;
      cnt_d    = 2'd0;
      acc_d    = 12'd0;
      emit     = 1'b1;
      cmd.op   = jsu_pkg::OP_SINGLE;
      cmd.kind = jsu_pkg::KIND_ERR;
      cmd.data = 8'h00;
      cmd.err  = fail_code;
      cmd.cp   = 21'd0;
    end
  end

  assign push_o = acc_i && emit;
  assign cmd_o  = cmd;

  // Advance parser state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_IDLE;
      cnt_q   <= 2'd0;
      acc_q   <= 12'd0;
      hs_q    <= 10'd0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// ----- src/jsu_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo
// Short command queue between the parser and the UTF-8 encoder.
// ----------------------------------------------------------------------------
module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t data_i,
  input  logic          pop_i,
  output jsu_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(jsu_pkg::QDepth);
  localparam int unsigned CntW = $clog2(jsu_pkg::QDepth + 1);

  jsu_pkg::cmd_t mem_q [jsu_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(jsu_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(jsu_pkg::QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(jsu_pkg::QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/jsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued commands into result items and holds the output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::cmd_t      cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  jsu_pkg::out_item_t data_q, data_d;

  logic       load;
  logic [1:0] last;

  assign load = !valid_q || out_ready_i;
  assign last = (cmd_i.op == jsu_pkg::OP_CODEPT) ? jsu_pkg::utf8_last(cmd_i.cp) : 2'd0;

  // Build next result from the queue head
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        data_d.kind     = cmd_i.kind;
        data_d.error_code = cmd_i.err;
        data_d.run_last = (idx_q == last);
        if (cmd_i.op == jsu_pkg::OP_CODEPT) begin
          data_d.out_byte = jsu_pkg::utf8_byte(cmd_i.cp, last, idx_q);
        end else begin
          data_d.out_byte = cmd_i.data;
        end
        if (idx_q == last) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- src/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a quoted JSON string, one raw byte per item, into UTF-8 bytes.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one raw byte per item,
// or an end-of-text marker. Output channel (out_valid_o / out_ready_i /
// out_data_o): decoded bytes, a completion item at the closing quote, or an
// error item; run_last flags the last result of each input item.
// Throughput: one input item per cycle while the command queue is not full. A
// \uXXXX escape yields 1 to 4 bytes, which the encoder emits one per cycle
// while the receiver takes them; a four-entry command queue lets the parser
// keep taking bytes meanwhile. The encoder's one-byte-per-cycle output sets
// the sustained rate when many escapes come back to back.
// Results of an item go through the command queue, then the output register.
// When the receiver stalls, the output register holds and the queue
// fills; in_ready_o drops only while the queue is full.
// Reset clears the parser to idle (awaiting an opening quote), empties the
// queue and drops out_valid_o.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_data_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  jsu_pkg::cmd_t cmd_in;
  jsu_pkg::cmd_t cmd_out;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  // Parse input bytes
  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (accept),
    .item_i (in_data_i),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  // Queue commands
  jsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // Encode and emit results
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/json_string_unescape_utf8_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string unescaper. A queue of raw bytes and
// end markers (directed strings, then random strings that are mostly
// well-formed, with broken escapes, bad surrogates and noise mixed in) feeds a
// bursty driver. A bit-accurate decoder model turns each accepted item into
// the UTF-8 bytes, completions and errors it should cause, and a monitor
// behind a stalling receiver checks every result against them in order.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;

  localparam int          CycleLimit    = 400000;
  localparam int          RandomItems   = 350;
  localparam int          SettleCycles  = 16;
  localparam int          HoldCycles    = 90;
  localparam int          HoldAfter     = 150;
  localparam logic [15:0] SurrHighMin   = 16'hD800;
  localparam logic [15:0] SurrHighMax   = 16'hDBFF;
  localparam logic [15:0] SurrLowMin    = 16'hDC00;
  localparam logic [15:0] SurrLowMax    = 16'hDFFF;
  localparam logic [20:0] SuppPlaneBase = 21'h10000;

  // One entry of the stimulus queue: a raw item, or a pause until all is out
  typedef struct {
    bit                pause;
    jsu_pkg::in_item_t item;
  } feed_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  jsu_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  jsu_pkg::out_item_t out_data_o;

  feed_t              feed_q[$];
  jsu_pkg::out_item_t decoded_q[$];
  jsu_pkg::out_item_t step_q[$];

  int mismatches  = 0;
  int items_taken = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int stall_mode  = 0;
  int mode_left   = 0;
  int cycles_run  = 0;

  // Decoder model state
  jsu_pkg::phase_e parse_phase  = jsu_pkg::PH_IDLE;
  logic [1:0]      digits_taken = '0;
  logic [15:0]     hex_acc      = '0;
  logic [9:0]      pending_high = '0;

  json_string_unescape_utf8 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // Bit 8 flags a known single-byte escape letter
  function automatic logic [8:0] unescape(input logic [7:0] c);
    case (c)
      jsu_pkg::ChQuote:  return {1'b1, 8'h22};
      jsu_pkg::ChBslash: return {1'b1, 8'h5C};
      jsu_pkg::ChSlash:  return {1'b1, 8'h2F};
      jsu_pkg::ChLowerB: return {1'b1, 8'h08};
      jsu_pkg::ChLowerF: return {1'b1, 8'h0C};
      jsu_pkg::ChLowerN: return {1'b1, 8'h0A};
      jsu_pkg::ChLowerR: return {1'b1, 8'h0D};
      jsu_pkg::ChLowerT: return {1'b1, 8'h09};
      default:           return 9'h000;
    endcase
  endfunction

  task automatic push_result(input jsu_pkg::kind_e k, input logic [7:0] b,
                             input jsu_pkg::err_e e);
    jsu_pkg::out_item_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.error_code = e;
    r.run_last   = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic flag_error(input jsu_pkg::err_e e);
    parse_phase  = jsu_pkg::PH_IDLE;
    digits_taken = '0;
    hex_acc      = '0;
    push_result(jsu_pkg::KIND_ERR, 8'h00, e);
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_result(jsu_pkg::KIND_DATA, cp[7:0], jsu_pkg::ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      push_result(jsu_pkg::KIND_DATA, 8'hC0 | 8'(cp >> 6), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      push_result(jsu_pkg::KIND_DATA, 8'hE0 | 8'(cp >> 12), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
    end else begin
      push_result(jsu_pkg::KIND_DATA, 8'hF0 | 8'((cp >> 18) & 21'h07), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 12) & 21'h3F), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3F), jsu_pkg::ERR_NONE);
      push_result(jsu_pkg::KIND_DATA, 8'h80 | 8'(cp & 21'h3F), jsu_pkg::ERR_NONE);
    end
  endtask

  // Advance the model by one accepted item and queue the results it causes
  task automatic predict_results(input jsu_pkg::in_item_t it);
    logic [7:0]  c;
    logic        at_end;
    logic [8:0]  esc;
    logic [15:0] v;
    int          d;
    c      = it.char_byte;
    at_end = it.input_end;
    step_q.delete();
    case (parse_phase)
      jsu_pkg::PH_BODY: begin
        if (at_end) begin
          flag_error(jsu_pkg::ERR_EARLY_END);
        end else if (c == jsu_pkg::ChQuote) begin
          parse_phase = jsu_pkg::PH_IDLE;
          push_result(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE);
        end else if (c == jsu_pkg::ChBslash) begin
          parse_phase = jsu_pkg::PH_ESC;
        end else begin
          push_result(jsu_pkg::KIND_DATA, c, jsu_pkg::ERR_NONE);
        end
      end
      jsu_pkg::PH_ESC: begin
        esc = unescape(c);
        if (at_end) begin
          flag_error(jsu_pkg::ERR_EARLY_END);
        end else if (c == jsu_pkg::ChLowerU) begin
          parse_phase  = jsu_pkg::PH_HEX1;
          digits_taken = '0;
          hex_acc      = '0;
        end else if (esc[8]) begin
          parse_phase = jsu_pkg::PH_BODY;
          push_result(jsu_pkg::KIND_DATA, esc[7:0], jsu_pkg::ERR_NONE);
        end else begin
          flag_error(jsu_pkg::ERR_BAD_ESCAPE);
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        d = hex_digit(c);
        if (at_end) begin
          flag_error(jsu_pkg::ERR_INCOMPLETE);
        end else if (d < 0) begin
          flag_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], 4'(d)};
          if (digits_taken != 2'd3) begin
            digits_taken = digits_taken + 2'd1;
          end else begin
            digits_taken = '0;
            v            = hex_acc;
            hex_acc      = '0;
            if (parse_phase == jsu_pkg::PH_HEX1) begin
              if (v >= SurrHighMin && v <= SurrHighMax) begin
                pending_high = v[9:0];
                parse_phase  = jsu_pkg::PH_WAIT_BS;
              end else if (v >= SurrLowMin && v <= SurrLowMax) begin
                flag_error(jsu_pkg::ERR_LONE_LOW);
              end else begin
                parse_phase = jsu_pkg::PH_BODY;
                emit_utf8({5'd0, v});
              end
            end else if (v < SurrLowMin || v > SurrLowMax) begin
              flag_error(jsu_pkg::ERR_BAD_LOW);
            end else begin
              parse_phase = jsu_pkg::PH_BODY;
              emit_utf8(SuppPlaneBase + {1'b0, pending_high, v[9:0]});
            end
          end
        end
      end
      jsu_pkg::PH_WAIT_BS: begin
        if (at_end || c != jsu_pkg::ChBslash) flag_error(jsu_pkg::ERR_MISSING_LOW);
        else parse_phase = jsu_pkg::PH_WAIT_U;
      end
      jsu_pkg::PH_WAIT_U: begin
        if (at_end || c != jsu_pkg::ChLowerU) begin
          flag_error(jsu_pkg::ERR_MISSING_LOW);
        end else begin
          parse_phase  = jsu_pkg::PH_HEX2;
          digits_taken = '0;
          hex_acc      = '0;
        end
      end
      default: begin
        if (at_end) flag_error(jsu_pkg::ERR_EARLY_END);
        else if (c != jsu_pkg::ChQuote) flag_error(jsu_pkg::ERR_NO_QUOTE);
        else parse_phase = jsu_pkg::PH_BODY;
      end
    endcase
    // Mark the last result of this item, then hand all of them to the checker
    if (step_q.size() != 0) begin
      step_q[step_q.size() - 1].run_last = 1'b1;
    end
    decoded_q = {decoded_q, step_q};
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c);
    feed_t f;
    f.pause = 1'b0;
    f.item  = '{char_byte: c, input_end: 1'b0};
    feed_q = {feed_q, f};
  endtask

  // The byte lane is don't-care on an end marker, so fill it at random
  task automatic add_end();
    feed_t f;
    f.pause = 1'b0;
    f.item  = '{char_byte: 8'($urandom_range(0, 255)), input_end: 1'b1};
    feed_q = {feed_q, f};
  endtask

  task automatic add_pause();
    feed_t f;
    f.pause = 1'b1;
    f.item  = '0;
    feed_q = {feed_q, f};
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(n) - 8'd10;
    return 8'h41 + 8'(n) - 8'd10;
  endfunction

  task automatic add_hex_digits(input int count);
    for (int i = 0; i < count; i++) add_byte(hex_char(4'($urandom_range(0, 15))));
  endtask

  task automatic add_u_escape(input logic [15:0] v);
    add_byte(jsu_pkg::ChBslash);
    add_byte(jsu_pkg::ChLowerU);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBslash);
    return c;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] pick_non_escape();
    logic [7:0] c;
    logic [8:0] esc;
    do begin
      c   = 8'($urandom_range(0, 255));
      esc = unescape(c);
    end while (esc[8] || c == jsu_pkg::ChLowerU);
    return c;
  endfunction

  function automatic logic [7:0] pick_other_than(input logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == avoid);
    return c;
  endfunction

  function automatic logic [15:0] pick_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      2: begin
        case ($urandom_range(0, 7))
          0:       v = 16'h0000;
          1:       v = 16'h007F;
          2:       v = 16'h0080;
          3:       v = 16'h07FF;
          4:       v = 16'h0800;
          5:       v = 16'hD7FF;
          6:       v = 16'hE000;
          default: v = 16'hFFFF;
        endcase
      end
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hFFFF));
        while (v >= SurrHighMin && v <= SurrLowMax);
      end
    endcase
    return v;
  endfunction

  function automatic logic [9:0] pick_surr_bits();
    case ($urandom_range(0, 5))
      0:       return 10'h000;
      1:       return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // High surrogate escape, then what follows it when the pair is broken
  task automatic add_broken_pair();
    logic [15:0] v;
    add_u_escape(SurrHighMin + {6'd0, pick_surr_bits()});
    case ($urandom_range(0, 5))
      0: add_byte(pick_other_than(jsu_pkg::ChBslash));
      1: add_end();
      2: begin
        add_byte(jsu_pkg::ChBslash);
        add_byte(pick_other_than(jsu_pkg::ChLowerU));
      end
      3: begin
        add_byte(jsu_pkg::ChBslash);
        add_end();
      end
      4: begin
        do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= SurrLowMin && v <= SurrLowMax);
        add_u_escape(v);
      end
      default: begin
        add_byte(jsu_pkg::ChBslash);
        add_byte(jsu_pkg::ChLowerU);
        add_hex_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) add_end();
        else add_byte(pick_non_hex());
      end
    endcase
  endtask

  // One quoted string with random content; most close cleanly, some break
  task automatic add_random_string();
    int segments;
    segments = $urandom_range(0, 7);
    // Drop some junk in front: stray bytes and end markers while idle
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) == 0) add_end();
        else add_byte(pick_other_than(jsu_pkg::ChQuote));
      end
    end
    add_byte(jsu_pkg::ChQuote);
    repeat (segments) begin
      case ($urandom_range(0, 9))
        4, 5: begin
          add_byte(jsu_pkg::ChBslash);
          case ($urandom_range(0, 7))
            0:       add_byte(jsu_pkg::ChQuote);
            1:       add_byte(jsu_pkg::ChBslash);
            2:       add_byte(jsu_pkg::ChSlash);
            3:       add_byte(jsu_pkg::ChLowerB);
            4:       add_byte(jsu_pkg::ChLowerF);
            5:       add_byte(jsu_pkg::ChLowerN);
            6:       add_byte(jsu_pkg::ChLowerR);
            default: add_byte(jsu_pkg::ChLowerT);
          endcase
        end
        6: add_u_escape(pick_bmp());
        7: begin
          add_u_escape(SurrHighMin + {6'd0, pick_surr_bits()});
          add_u_escape(SurrLowMin + {6'd0, pick_surr_bits()});
        end
        default: add_byte(pick_plain());
      endcase
    end
    case ($urandom_range(0, 19))
      12: add_end();
      13: begin
        add_byte(jsu_pkg::ChBslash);
        if ($urandom_range(0, 1) == 0) add_end();
        else add_byte(pick_non_escape());
      end
      14, 15: begin
        add_byte(jsu_pkg::ChBslash);
        add_byte(jsu_pkg::ChLowerU);
        add_hex_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) add_end();
        else add_byte(pick_non_hex());
      end
      16: add_u_escape(SurrLowMin + {6'd0, pick_surr_bits()});
      17, 18: add_broken_pair();
      default: add_byte(jsu_pkg::ChQuote);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of items with random gaps, pausing on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    feed_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_results(in_data_i);
        items_taken <= items_taken + 1;
      end
      // Offer the next item only once the current one is gone
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (feed_q.size() != 0 && feed_q[0].pause) begin
          in_valid_i <= 1'b0;
          if (decoded_q.size() == 0) void'(feed_q.pop_front());
        end else if (feed_q.size() != 0) begin
          nxt        = feed_q.pop_front();
          in_data_i  <= nxt.item;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern that changes mode, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && items_taken >= HoldAfter) begin
        hold_done   <= 1'b1;
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(16, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check
    jsu_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d byte %02h err %0d last %0d",
                 $time, out_data_o.kind, out_data_o.out_byte, out_data_o.error_code,
                 out_data_o.run_last);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data_o.kind !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d, got %0d",
                   $time, want.kind, out_data_o.kind);
          mismatches++;
        end
        if (out_data_o.out_byte !== want.out_byte) begin
          $display("%0t: out_byte mismatch, expected %02h, got %02h",
                   $time, want.out_byte, out_data_o.out_byte);
          mismatches++;
        end
        if (out_data_o.error_code !== want.error_code) begin
          $display("%0t: error_code mismatch, expected %0d, got %0d",
                   $time, want.error_code, out_data_o.error_code);
          mismatches++;
        end
        if (out_data_o.run_last !== want.run_last) begin
          $display("%0t: run_last mismatch, expected %0d, got %0d",
                   $time, want.run_last, out_data_o.run_last);
          mismatches++;
        end
      end
    end
  end

  // Give up on a hung run
  initial begin
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int base;
    bit paused;
    // Stray byte and end marker while idle
    add_byte(8'hFF);
    add_end();
    // Byte extremes, then the largest code point from a surrogate pair
    add_byte(jsu_pkg::ChQuote);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_u_escape(SurrHighMax);
    add_u_escape(SurrLowMax);
    add_byte(jsu_pkg::ChQuote);
    // Low surrogate with no high one before it
    add_byte(jsu_pkg::ChQuote);
    add_u_escape(SurrLowMin);
    // Text ends inside the string body
    add_byte(jsu_pkg::ChQuote);
    add_end();
    add_pause();

    base   = feed_q.size();
    paused = 1'b0;
    while (feed_q.size() < base + RandomItems) begin
      add_random_string();
      if (!paused && feed_q.size() >= base + RandomItems / 2) begin
        add_pause();
        paused = 1'b1;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all items to go in and all results to come out
    while (feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, decoded_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_fifo.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_tb.sv
